// File: rtl/sqht_pkg.sv
// Shared types, codes and threshold function for the squelch hang timer.
package sqht_pkg;

  localparam int unsigned StrengthW = 16;
  localparam int unsigned LevelW    = 4;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned OutDataW  = 8;

  localparam logic [LevelW-1:0] LevelS9    = 4'd9;
  localparam logic [LevelW-1:0] LevelPlus10 = 4'd10;
  localparam logic [LevelW-1:0] LevelPlus20 = 4'd11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_S9      = 2'd0,
    REG_LEVEL   = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_ON      = 2'd3
  } sqht_reg_t;

  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_ENABLED  = 3'd1,
    ST_RISE     = 3'd2,
    ST_HIGH     = 3'd3,
    ST_FALL     = 3'd4,
    ST_LOW      = 3'd5,
    ST_TIMEOUT  = 3'd6
  } sqht_state_t;

  typedef struct packed {
    logic load;
    logic on;
  } sqht_cmd_t;

  function automatic logic [StrengthW-1:0] sqht_threshold(
    input logic [StrengthW-1:0] s9,
    input logic [LevelW-1:0]    lvl
  );
    logic [LevelW-1:0] sh;
    logic [StrengthW-1:0] r;
    sh = LevelS9 - lvl;
    if (lvl <= LevelS9) begin
      r = StrengthW'($signed(s9) >>> sh);
    end else if (lvl == LevelPlus10) begin
      r = (s9 << 1) + s9;
    end else if (lvl == LevelPlus20) begin
      r = (s9 << 3) + (s9 << 1);
    end else begin
      r = (s9 << 5) - s9;
    end
    return r;
  endfunction

endpackage

// File: rtl/sqht_fsm.sv
// Squelch state machine with hang counter and threshold compare.
module sqht_fsm
  import sqht_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [StrengthW-1:0] sample,
  input  logic [StrengthW-1:0] thr,
  input  logic [TimeoutW-1:0]  timeout,
  input  sqht_cmd_t            cmd,
  output sqht_state_t          state_nxt,
  output logic                 hi
);

  sqht_state_t         state_r;
  logic [TimeoutW-1:0] hang_r;
  logic [TimeoutW-1:0] hang_nxt;
  logic [TimeoutW-1:0] hang_dec;

  assign hi       = $signed(sample) > $signed(thr);
  assign hang_dec = hang_r - TimeoutW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DISABLED;
      hang_r  <= '0;
    end else begin
      if (cmd.load) begin
        state_r <= cmd.on ? ST_ENABLED : ST_DISABLED;
      end else if (step) begin
        state_r <= state_nxt;
        hang_r  <= hang_nxt;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    hang_nxt  = hang_r;
    unique case (state_r)
      ST_ENABLED: begin
        state_nxt = hi ? ST_RISE : ST_ENABLED;
      end
      ST_RISE, ST_HIGH: begin
        state_nxt = hi ? ST_HIGH : ST_FALL;
      end
      ST_FALL: begin
        state_nxt = hi ? ST_HIGH : ST_LOW;
        hang_nxt  = timeout;
      end
      ST_LOW: begin
        hang_nxt = hang_dec;
        if (hang_dec == '0) begin
          state_nxt = ST_TIMEOUT;
        end else if (hi) begin
          state_nxt = ST_HIGH;
        end
      end
      ST_TIMEOUT: begin
        state_nxt = ST_ENABLED;
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_timeout_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cmd.load && state_r == ST_TIMEOUT) |=> state_r == ST_ENABLED)
    else $error("timeout did not re-arm");

  a_fall_load: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cmd.load && state_r == ST_FALL) |=> hang_r == $past(timeout))
    else $error("hang counter not loaded on fall");

  a_low_expire: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cmd.load && state_r == ST_LOW && hang_r == TimeoutW'(1))
      |=> state_r == ST_TIMEOUT)
    else $error("hang expiry missed");

  a_cfg_off: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !cmd.on) |=> state_r == ST_DISABLED)
    else $error("disable write ignored");
`endif

endmodule

// File: rtl/squelch_hang_timer_fsm_core.sv
// Squelch with hang timer: top level with stream channels and register port.
//
// Input channel in_*: one signed 16-bit strength sample per transfer.
// Result channel out_*: one transfer per sample, carrying the squelch state
// after that sample and whether the sample exceeded the latched threshold.
// Register port cfg_*: always ready; write while the block is idle.
//   0 S9 calibration, 1 S-level, 2 hang timeout, 3 squelch on/off.
//   Writing 1 to register 3 latches the threshold and restarts at enabled.
// Path: a sample is held in the input register, compared and stepped through the
// state machine, and its result is written to the output register once it can advance.
// Throughput: one sample per cycle while out_tready stays high, set by the
// combinational compare and state update between the input and result registers.
// Reset: state disabled, hang counter and threshold zero, timeout one,
// both pipeline registers empty.
// Stall: with out_tready low the result holds; the input register still
// takes one more sample, then in_tready drops until the result moves.
module squelch_hang_timer_fsm_core
  import sqht_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [StrengthW-1:0] in_tdata,   // [15:0] strength
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutDataW-1:0]  out_tdata,  // [2:0] squelch_state, [3] above_threshold
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  logic [StrengthW-1:0] s9_r;
  logic [LevelW-1:0]    level_r;
  logic [TimeoutW-1:0]  timeout_r;
  logic [StrengthW-1:0] thr_r;

  logic                 in_valid_r;
  logic [StrengthW-1:0] in_data_r;
  logic                 out_valid_r;
  logic [OutDataW-1:0]  out_data_r;

  logic        advance;
  logic        step;
  logic        cfg_fire;
  sqht_cmd_t   cmd;
  sqht_state_t state_nxt;
  logic        hi;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cmd.load  = cfg_fire && (cfg_index == REG_ON);
  assign cmd.on    = cfg_data[0];

  assign advance    = !out_valid_r || out_tready;
  assign step       = in_valid_r && advance;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_r      <= '0;
      level_r   <= '0;
      timeout_r <= TimeoutW'(1);
      thr_r     <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_S9:      s9_r      <= cfg_data[StrengthW-1:0];
        REG_LEVEL:   level_r   <= cfg_data[LevelW-1:0];
        REG_TIMEOUT: timeout_r <= cfg_data[TimeoutW-1:0];
        REG_ON: begin
          if (cfg_data[0]) begin
            thr_r <= sqht_threshold(s9_r, level_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
    if (step) begin
      out_data_r <= {4'b0000, hi, state_nxt};
    end
  end

  sqht_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .sample    (in_data_r),
    .thr       (thr_r),
    .timeout   (timeout_r),
    .cmd       (cmd),
    .state_nxt (state_nxt),
    .hi        (hi)
  );

`ifndef SYNTHESIS
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r && $stable(in_data_r))
    else $error("input register lost a sample under stall");

  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed sample produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_valid_r && advance) |=> !out_valid_r)
    else $error("result without a sample");
`endif

endmodule
